### rtl/oil_pkg.sv
// Shared constants, tables and saturation helpers of the octahedral invariant pipeline.
`default_nettype none

package oil_pkg;

	// Radicand and root widths of the integer square root units.
	localparam int RAD_W       = 68;
	localparam int ROOT_W      = 34;
	localparam int SQRT_STAGES = ROOT_W;

	// Reciprocal multiplier for an exact floor division by three of values below 2^35.
	localparam int         DIV3_SHIFT = 35;
	localparam logic [33:0] DIV3_MULT = 34'd11453246123;
	localparam int         DIV3_LAT   = 2;

	// Angle unit: six normalizing stages, the rotation steps and one clamp stage.
	localparam int CORDIC_STEPS = 23;
	localparam int NORM_STAGES  = 6;
	localparam int CORDIC_LAT   = NORM_STAGES + CORDIC_STEPS + 1;

	// Ninety degrees with sixteen fraction bits.
	localparam logic [22:0] DEG90 = 23'd5898240;

	// Step angles atan(2^-i) in degrees with sixteen fraction bits.
	localparam logic [22:0] ATAN_DEG [CORDIC_STEPS] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
		23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
		23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2, 23'd1
	};

	// Total pipeline depth from input register to output register.
	localparam int PIPE_DEPTH = 3 + SQRT_STAGES + DIV3_LAT + 1 + CORDIC_LAT + 1;

	// Clamp an unsigned value to the 31 bit result range.
	function automatic logic [30:0] sat_u31(input logic [33:0] v);
		return (|v[33:31]) ? 31'h7FFFFFFF : v[30:0];
	endfunction

	// Clamp a signed value to the 32 bit result range.
	function automatic logic [31:0] sat_s32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'h7FFFFFFF;
		else if (v < -35'sd2147483648)
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/oil_isqrt.sv
// Fully pipelined floor square root, one result bit per register stage.
`default_nettype none

module oil_isqrt
	import oil_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad,
	output logic      [ROOT_W-1:0] root
);

	logic [ROOT_W+2:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0]  root_s [SQRT_STAGES];
	logic [RAD_W-1:0]   rad_s  [SQRT_STAGES];

	// Each stage brings down two radicand bits and tries one root bit.
	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
		logic [ROOT_W+2:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W+2:0] rem_sh;
		logic [ROOT_W+2:0] trial;
		logic              fits;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
		end

		assign rem_sh = {rem_in[ROOT_W:0], rad_in[RAD_W-1:RAD_W-2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign fits   = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? (rem_sh - trial) : rem_sh;
				root_s[i] <= {root_in[ROOT_W-2:0], fits};
				rad_s[i]  <= {rad_in[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQRT_STAGES-1];

endmodule

`default_nettype wire

### rtl/oil_div3.sv
// Two stage exact floor division by three through a reciprocal multiply.
`default_nettype none

module oil_div3
	import oil_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [33:0] num,
	output logic      [32:0] quo
);

	logic [67:0] prod_s1;
	logic [32:0] quo_s2;

	// Multiply first, then keep the high part of the product.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= num * DIV3_MULT;
			quo_s2  <= prod_s1[67:DIV3_SHIFT];
		end
	end

	assign quo = quo_s2;

endmodule

`default_nettype wire

### rtl/oil_cordic.sv
// Pipelined vectoring CORDIC that gives the angle of (x, y) in degrees.
`default_nettype none

module oil_cordic
	import oil_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [33:0] x_in,
	input  wire logic [32:0] y_in,
	output logic      [22:0] ang
);

	logic [34:0]        nx_s [NORM_STAGES];
	logic [34:0]        ny_s [NORM_STAGES];
	logic signed [37:0] cx_s [CORDIC_STEPS];
	logic signed [37:0] cy_s [CORDIC_STEPS];
	logic signed [24:0] cz_s [CORDIC_STEPS];
	logic [22:0]        ang_s;

	// Normalize so that the larger coordinate has its leading one at bit 34.
	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int K = 32 >> j;
		logic [34:0] a_in;
		logic [34:0] b_in;
		logic        top_clear;

		if (j == 0) begin : g_first
			assign a_in = {1'b0, x_in};
			assign b_in = {2'b00, y_in};
		end else begin : g_next
			assign a_in = nx_s[j-1];
			assign b_in = ny_s[j-1];
		end

		assign top_clear = (((a_in | b_in) >> (35 - K)) == 35'd0);

		always_ff @(posedge clk) begin
			if (en) begin
				nx_s[j] <= top_clear ? (a_in << K) : a_in;
				ny_s[j] <= top_clear ? (b_in << K) : b_in;
			end
		end
	end

	// One rotation step per stage, driving y toward zero.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [37:0] x_cur;
		logic signed [37:0] y_cur;
		logic signed [24:0] z_cur;
		logic signed [37:0] xs;
		logic signed [37:0] ys;
		logic signed [24:0] step;

		if (i == 0) begin : g_first
			assign x_cur = $signed({3'b000, nx_s[NORM_STAGES-1]});
			assign y_cur = $signed({3'b000, ny_s[NORM_STAGES-1]});
			assign z_cur = '0;
		end else begin : g_next
			assign x_cur = cx_s[i-1];
			assign y_cur = cy_s[i-1];
			assign z_cur = cz_s[i-1];
		end

		assign xs   = x_cur >>> i;
		assign ys   = y_cur >>> i;
		assign step = $signed({2'b00, ATAN_DEG[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_cur[37]) begin
					cx_s[i] <= x_cur + ys;
					cy_s[i] <= y_cur - xs;
					cz_s[i] <= z_cur + step;
				end else begin
					cx_s[i] <= x_cur - ys;
					cy_s[i] <= y_cur + xs;
					cz_s[i] <= z_cur - step;
				end
			end
		end
	end

	// Clamp the accumulated angle to the first quadrant.
	always_ff @(posedge clk) begin
		if (en) begin
			if (cz_s[CORDIC_STEPS-1] < 25'sd0)
				ang_s <= '0;
			else if (cz_s[CORDIC_STEPS-1] > $signed({2'b00, DEG90}))
				ang_s <= DEG90;
			else
				ang_s <= cz_s[CORDIC_STEPS-1][22:0];
		end
	end

	assign ang = ang_s;

endmodule

`default_nettype wire

### rtl/octahedral_invariants_lode.sv
// Top level of the octahedral stress, strain and Lode angle pipeline.
//
// Usage: one item on the input channel carries the diagonal of a stress
// tensor and of a strain tensor, six signed fixed point words with 16
// fraction bits. One result item leaves on the output channel for each
// input item, in order. Both channels use valid and ready.
// Throughput is one item per cycle while the receiver takes results: the
// work is a linear pipeline of three front stages, a 34 stage square root,
// a two stage divide by three, a post stage, a 30 stage CORDIC and an
// output register. All stages advance together; when the output holds a
// result that the receiver does not take, the whole pipeline holds and
// in_ready falls, so nothing is lost or repeated. Empty stages, too, move
// on only when the output register is free or being emptied.
// Reset clears all valid bits; no result is shown until items arrive.
`default_nettype none

module octahedral_invariants_lode
	import oil_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] stress_xx,
	input  wire logic signed [31:0] stress_yy,
	input  wire logic signed [31:0] stress_zz,
	input  wire logic signed [31:0] strain_xx,
	input  wire logic signed [31:0] strain_yy,
	input  wire logic signed [31:0] strain_zz,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      mean_stress,
	output logic        [30:0]      oct_shear_stress,
	output logic signed [31:0]      mean_strain,
	output logic        [30:0]      oct_shear_strain,
	output logic        [30:0]      dev_sx,
	output logic signed [31:0]      dev_sy,
	output logic signed [23:0]      lode_deg,
	output logic                    angle_undefined
);

	typedef struct packed {
		logic        ms_neg;
		logic [32:0] ms_mag;
		logic        me_neg;
		logic [32:0] me_mag;
		logic [33:0] sy;
	} side_a_t;

	typedef struct packed {
		logic        ms_neg;
		logic        me_neg;
		logic [33:0] sy;
		logic [32:0] sx;
	} side_b_t;

	typedef struct packed {
		logic [31:0] mean_ss;
		logic [30:0] shear_ss;
		logic [31:0] mean_se;
		logic [30:0] shear_se;
		logic [30:0] sx;
		logic [31:0] sy;
		logic        zero;
		logic        force90;
		logic        neg;
		logic        undef;
	} side_c_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] d);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	logic                   adv;
	logic [PIPE_DEPTH-1:0]  vld_s;

	// Stage 1 registers.
	logic signed [33:0] sum_ss_s1, sum_se_s1;
	logic [32:0]        ds1_s1, ds2_s1, ds3_s1, de1_s1, de2_s1, de3_s1, dyz_s1;
	logic signed [34:0] sy_num_s1;

	// Stage 2 registers.
	logic [65:0]        qs1_s2, qs2_s2, qs3_s2, qe1_s2, qe2_s2, qe3_s2, qyz_s2;
	side_a_t            side_s2;

	// Stage 3 registers.
	logic [RAD_W-1:0]   rad_ss_s3, rad_se_s3, rad_sx_s3;
	side_a_t            side_s3;

	logic [ROOT_W-1:0]  root_ss, root_se, root_sx;
	side_a_t            side_a_s [SQRT_STAGES];
	side_b_t            side_b_s [DIV3_LAT];
	logic [32:0]        q_ms, q_me, q_ss, q_se;

	// Post stage registers.
	side_c_t            side_s4;
	logic [33:0]        cx_s4;
	logic [32:0]        cy_s4;

	side_c_t            side_c_s [CORDIC_LAT];
	logic [22:0]        ang;

	// Output registers.
	logic [31:0]        mean_ss_s5, mean_se_s5, sy_s5;
	logic [30:0]        shear_ss_s5, shear_se_s5, sx_s5;
	logic [23:0]        lode_s5;
	logic               undef_s5;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv       = !vld_s[PIPE_DEPTH-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[PIPE_DEPTH-1];

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: sums, pairwise difference magnitudes and the numerator of sy.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_ss_s1 <= 34'(stress_xx) + 34'(stress_yy) + 34'(stress_zz);
			sum_se_s1 <= 34'(strain_xx) + 34'(strain_yy) + 34'(strain_zz);
			ds1_s1    <= mag33(33'(stress_xx) - 33'(stress_yy));
			ds2_s1    <= mag33(33'(stress_yy) - 33'(stress_zz));
			ds3_s1    <= mag33(33'(stress_zz) - 33'(stress_xx));
			de1_s1    <= mag33(33'(strain_xx) - 33'(strain_yy));
			de2_s1    <= mag33(33'(strain_yy) - 33'(strain_zz));
			de3_s1    <= mag33(33'(strain_zz) - 33'(strain_xx));
			dyz_s1    <= mag33(33'(stress_yy) - 33'(stress_zz));
			sy_num_s1 <= 35'(stress_xx) + 35'(stress_xx) - 35'(stress_yy) - 35'(stress_zz);
		end
	end

	// Stage 2: squares, signs and magnitudes of the sums, and the truncated half of sy.
	always_ff @(posedge clk) begin
		logic [34:0] sy_mag;
		if (adv) begin
			sy_mag         = sy_num_s1[34] ? 35'(-sy_num_s1) : 35'(sy_num_s1);
			qs1_s2         <= ds1_s1 * ds1_s1;
			qs2_s2         <= ds2_s1 * ds2_s1;
			qs3_s2         <= ds3_s1 * ds3_s1;
			qe1_s2         <= de1_s1 * de1_s1;
			qe2_s2         <= de2_s1 * de2_s1;
			qe3_s2         <= de3_s1 * de3_s1;
			qyz_s2         <= dyz_s1 * dyz_s1;
			side_s2.ms_neg <= sum_ss_s1[33];
			side_s2.ms_mag <= sum_ss_s1[33] ? 33'(-sum_ss_s1) : 33'(sum_ss_s1);
			side_s2.me_neg <= sum_se_s1[33];
			side_s2.me_mag <= sum_se_s1[33] ? 33'(-sum_se_s1) : 33'(sum_se_s1);
			side_s2.sy     <= sy_num_s1[34] ? 34'(-(sy_mag >> 1)) : 34'(sy_mag >> 1);
		end
	end

	// Stage 3: radicands of the three square roots.
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_ss_s3 <= 68'(qs1_s2) + 68'(qs2_s2) + 68'(qs3_s2);
			rad_se_s3 <= (68'(qe1_s2) + 68'(qe2_s2) + 68'(qe3_s2)) << 2;
			rad_sx_s3 <= 68'(qyz_s2) + (68'(qyz_s2) << 1);
			side_s3   <= side_s2;
		end
	end

	oil_isqrt u_sqrt_ss (.clk(clk), .en(adv), .rad(rad_ss_s3), .root(root_ss));
	oil_isqrt u_sqrt_se (.clk(clk), .en(adv), .rad(rad_se_s3), .root(root_se));
	oil_isqrt u_sqrt_sx (.clk(clk), .en(adv), .rad(rad_sx_s3), .root(root_sx));

	// Side data waits out the square root latency.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_a_s[0] <= side_s3;
			for (int i = 1; i < SQRT_STAGES; i++)
				side_a_s[i] <= side_a_s[i-1];
		end
	end

	oil_div3 u_div_ms (.clk(clk), .en(adv), .num({1'b0, side_a_s[SQRT_STAGES-1].ms_mag}),
		.quo(q_ms));
	oil_div3 u_div_me (.clk(clk), .en(adv), .num({1'b0, side_a_s[SQRT_STAGES-1].me_mag}),
		.quo(q_me));
	oil_div3 u_div_ss (.clk(clk), .en(adv), .num(root_ss), .quo(q_ss));
	oil_div3 u_div_se (.clk(clk), .en(adv), .num(root_se), .quo(q_se));

	// Side data waits out the divider latency.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_b_s[0].ms_neg <= side_a_s[SQRT_STAGES-1].ms_neg;
			side_b_s[0].me_neg <= side_a_s[SQRT_STAGES-1].me_neg;
			side_b_s[0].sy     <= side_a_s[SQRT_STAGES-1].sy;
			side_b_s[0].sx     <= root_sx[ROOT_W-1:1];
			for (int i = 1; i < DIV3_LAT; i++)
				side_b_s[i] <= side_b_s[i-1];
		end
	end

	// Post stage: signs, saturation and the special cases of the angle.
	always_ff @(posedge clk) begin
		side_b_t            b;
		logic signed [34:0] ms_val;
		logic signed [34:0] me_val;
		logic               sx_zero;
		logic               sy_zero;
		if (adv) begin
			b       = side_b_s[DIV3_LAT-1];
			ms_val  = b.ms_neg ? -$signed({2'b00, q_ms}) : $signed({2'b00, q_ms});
			me_val  = b.me_neg ? -$signed({2'b00, q_me}) : $signed({2'b00, q_me});
			sx_zero = (b.sx == 33'd0);
			sy_zero = (b.sy == 34'd0);
			side_s4.mean_ss  <= sat_s32(ms_val);
			side_s4.mean_se  <= sat_s32(me_val);
			side_s4.shear_ss <= sat_u31({1'b0, q_ss});
			side_s4.shear_se <= sat_u31({1'b0, q_se});
			side_s4.sx       <= sat_u31({1'b0, b.sx});
			side_s4.sy       <= sat_s32(35'($signed(b.sy)));
			side_s4.zero     <= sx_zero;
			side_s4.force90  <= !sx_zero && sy_zero;
			side_s4.neg      <= b.sy[33];
			side_s4.undef    <= sx_zero && sy_zero;
			cx_s4            <= b.sy[33] ? 34'(-b.sy) : b.sy;
			cy_s4            <= b.sx;
		end
	end

	oil_cordic u_cordic (.clk(clk), .en(adv), .x_in(cx_s4), .y_in(cy_s4), .ang(ang));

	// Side data waits out the CORDIC latency.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_c_s[0] <= side_s4;
			for (int i = 1; i < CORDIC_LAT; i++)
				side_c_s[i] <= side_c_s[i-1];
		end
	end

	// Output register: final angle selection.
	always_ff @(posedge clk) begin
		side_c_t c;
		if (adv) begin
			c           = side_c_s[CORDIC_LAT-1];
			mean_ss_s5  <= c.mean_ss;
			mean_se_s5  <= c.mean_se;
			shear_ss_s5 <= c.shear_ss;
			shear_se_s5 <= c.shear_se;
			sx_s5       <= c.sx;
			sy_s5       <= c.sy;
			undef_s5    <= c.undef;
			if (c.zero)
				lode_s5 <= '0;
			else if (c.force90)
				lode_s5 <= {1'b0, DEG90};
			else if (c.neg)
				lode_s5 <= -{1'b0, ang};
			else
				lode_s5 <= {1'b0, ang};
		end
	end

	assign mean_stress      = mean_ss_s5;
	assign mean_strain      = mean_se_s5;
	assign oct_shear_stress = shear_ss_s5;
	assign oct_shear_strain = shear_se_s5;
	assign dev_sx           = sx_s5;
	assign dev_sy           = sy_s5;
	assign lode_deg         = lode_s5;
	assign angle_undefined  = undef_s5;

endmodule

`default_nettype wire

### rtl/oil_checker.sv
// Port level checks of the invariant pipeline and their binding to the top level.
`default_nettype none

module oil_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic        [30:0] dev_sx,
	input wire logic signed [31:0] dev_sy,
	input wire logic signed [23:0] lode_deg,
	input wire logic               angle_undefined
);

	// A held result keeps its angle.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lode_deg))
		else $error("result changed while stalled");

	// An undefined angle reads as zero and comes with a zero dev_sx.
	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && angle_undefined |-> lode_deg == 24'sd0 && dev_sx == 31'd0)
		else $error("undefined angle is not zero");

	// The angle stays within plus and minus ninety degrees.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lode_deg <= 24'sd5898240 && lode_deg >= -24'sd5898240)
		else $error("angle out of range");

	// A point on the sx axis lies at ninety degrees.
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dev_sx != 31'd0 && dev_sy == 32'sd0 |-> lode_deg == 24'sd5898240)
		else $error("angle on sx axis is not ninety");

endmodule

bind octahedral_invariants_lode oil_checker u_oil_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.dev_sx(dev_sx),
	.dev_sy(dev_sy),
	.lode_deg(lode_deg),
	.angle_undefined(angle_undefined)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the octahedral stress, strain and Lode angle pipeline.
`default_nettype none

module tb_top
	import oil_pkg::*;
();

	typedef struct {
		logic signed [31:0] s_xx, s_yy, s_zz, e_xx, e_yy, e_zz;
	} sample_t;

	typedef struct {
		logic signed [31:0] mean_s;
		logic        [30:0] shear_s;
		logic signed [31:0] mean_e;
		logic        [30:0] shear_e;
		logic        [30:0] sx;
		logic signed [31:0] sy;
		logic signed [23:0] lode;
		logic               undef;
	} invariants_t;

	// Floor square root of a 72 bit value.
	function automatic logic [35:0] floor_sqrt(input logic [71:0] v);
		logic [39:0] rem;
		logic [39:0] trial;
		logic [35:0] root;
		rem = '0;
		root = '0;
		for (int p = 35; p >= 0; p--) begin
			rem = (rem << 2) | v[2*p +: 2];
			root = root << 1;
			trial = ({4'd0, root} << 1) | 40'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root[0] = 1'b1;
			end
		end
		return root;
	endfunction

	function automatic logic [71:0] sq_mag(input longint d);
		logic [71:0] m;
		m = (d < 0) ? 72'(-d) : 72'(d);
		return m * m;
	endfunction

	function automatic logic [30:0] clamp_u31(input longint unsigned v);
		return (v > 64'h7FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
	endfunction

	function automatic logic [31:0] clamp_s32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// Vectoring rotation of (x, y) giving the angle in degrees, 16 fraction bits.
	function automatic longint rotate_angle(input longint x0, input longint y0);
		longint x, y, z, xs, ys;
		x = x0;
		y = y0;
		z = 0;
		while ((x > y ? x : y) < (64'sd1 <<< 34)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ATAN_DEG[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ATAN_DEG[i]);
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'(DEG90))
			z = longint'(DEG90);
		return z;
	endfunction

	// Invariants of one sample.
	function automatic invariants_t invariants_of(input sample_t s);
		invariants_t r;
		longint a, b, c, sy, lode;
		longint unsigned sx;
		logic [71:0] acc;
		a = s.s_xx;
		b = s.s_yy;
		c = s.s_zz;
		r.mean_s = clamp_s32((a + b + c) / 3);
		acc = sq_mag(a - b) + sq_mag(b - c) + sq_mag(c - a);
		r.shear_s = clamp_u31(64'(floor_sqrt(acc) / 3));
		sx = 64'(floor_sqrt(3 * sq_mag(b - c)) / 2);
		sy = (2 * a - b - c) / 2;
		r.sx = clamp_u31(sx);
		r.sy = clamp_s32(sy);
		a = s.e_xx;
		b = s.e_yy;
		c = s.e_zz;
		r.mean_e = clamp_s32((a + b + c) / 3);
		acc = (sq_mag(a - b) + sq_mag(b - c) + sq_mag(c - a)) << 2;
		r.shear_e = clamp_u31(64'(floor_sqrt(acc) / 3));
		r.undef = 1'b0;
		if (sx == 0) begin
			lode = 0;
			r.undef = (sy == 0);
		end else if (sy == 0) begin
			lode = longint'(DEG90);
		end else begin
			lode = rotate_angle(sy < 0 ? -sy : sy, longint'(sx));
			if (sy < 0)
				lode = -lode;
		end
		r.lode = lode[23:0];
		return r;
	endfunction

	// Holds the expected invariants of accepted samples in order and checks each result against the oldest.
	class invariant_scoreboard;
		invariants_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_sample(sample_t s);
			pending.insert(pending.size(), invariants_of(s));
		endfunction

		function void field_check(string name, longint e, longint a);
			if (e != a) begin
				$display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(invariants_t got);
			invariants_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result item", $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			field_check("mean_stress", e.mean_s, got.mean_s);
			field_check("oct_shear_stress", e.shear_s, got.shear_s);
			field_check("mean_strain", e.mean_e, got.mean_e);
			field_check("oct_shear_strain", e.shear_e, got.shear_e);
			field_check("dev_sx", e.sx, got.sx);
			field_check("dev_sy", e.sy, got.sy);
			field_check("lode_deg", e.lode, got.lode);
			field_check("angle_undefined", e.undef, got.undef);
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] stress_xx, stress_yy, stress_zz, strain_xx, strain_yy, strain_zz;
	logic signed [31:0] mean_stress, mean_strain, dev_sy;
	logic [30:0] oct_shear_stress, oct_shear_strain, dev_sx;
	logic signed [23:0] lode_deg;
	logic angle_undefined;

	invariant_scoreboard sb;
	int snd_idle_pct, rcv_idle_pct;
	bit hold_req;

	octahedral_invariants_lode dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stress_xx(stress_xx), .stress_yy(stress_yy), .stress_zz(stress_zz),
		.strain_xx(strain_xx), .strain_yy(strain_yy), .strain_zz(strain_zz),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_stress(mean_stress), .oct_shear_stress(oct_shear_stress),
		.mean_strain(mean_strain), .oct_shear_strain(oct_shear_strain),
		.dev_sx(dev_sx), .dev_sy(dev_sy), .lode_deg(lode_deg),
		.angle_undefined(angle_undefined)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#3000000;
		$display("tb_top: FAIL");
		$finish;
	end

	// Receiver: checks every taken result; random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		invariants_t got;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.mean_s = mean_stress;
				got.shear_s = oct_shear_stress;
				got.mean_e = mean_strain;
				got.shear_e = oct_shear_strain;
				got.sx = dev_sx;
				got.sy = dev_sy;
				got.lode = lode_deg;
				got.undef = angle_undefined;
				sb.check_result(got);
			end
			if (hold_req && hold_left == 0) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= arst_n && ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offer one item, after an optional random idle gap, and wait until it is taken.
	task automatic send_sample(input sample_t s);
		if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		stress_xx <= s.s_xx;
		stress_yy <= s.s_yy;
		stress_zz <= s.s_zz;
		strain_xx <= s.e_xx;
		strain_yy <= s.e_yy;
		strain_zz <= s.e_zz;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_sample(s);
	endtask

	// Random word: full range, small magnitude, or an extreme.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return 32'($signed($urandom_range(4000)) - 2000);
			7:          return 32'h7FFFFFFF - $urandom_range(3);
			8:          return 32'h80000000 + $urandom_range(3);
			default:    return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.s_xx = rand_word();
		s.s_yy = rand_word();
		s.s_zz = rand_word();
		s.e_xx = rand_word();
		s.e_yy = rand_word();
		s.e_zz = rand_word();
		// Steer some samples onto the axes of the deviatoric plane.
		case ($urandom_range(9))
			0: s.s_zz = s.s_yy;
			1: begin
				s.s_yy = $signed($urandom_range(1 << 20)) - (1 << 19);
				s.s_zz = $signed($urandom_range(1 << 20)) - (1 << 19);
				s.s_xx = 32'((longint'(s.s_yy) + longint'(s.s_zz)) / 2);
			end
			2: begin
				s.s_yy = s.s_xx;
				s.s_zz = s.s_xx;
			end
			default: ;
		endcase
		return s;
	endfunction

	localparam logic signed [31:0] MAXW = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MINW = 32'sh80000000;

	initial begin
		sample_t directed[$];
		sample_t s;
		sb = new();
		snd_idle_pct = 16;
		rcv_idle_pct = 76;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{stress_xx, stress_yy, stress_zz, strain_xx, strain_yy, strain_zz} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zeros, extremes, axis cases and sign of the angle.
		directed.insert(directed.size(), '{0, 0, 0, 0, 0, 0});
		directed.insert(directed.size(), '{MAXW, MAXW, MAXW, MAXW, MAXW, MAXW});
		directed.insert(directed.size(), '{MINW, MINW, MINW, MINW, MINW, MINW});
		directed.insert(directed.size(), '{MAXW, MINW, MAXW, MINW, MAXW, MINW});
		directed.insert(directed.size(), '{MINW, MAXW, MINW, MAXW, MINW, MAXW});
		directed.insert(directed.size(), '{MAXW, MINW, MINW, MAXW, MINW, MINW});
		directed.insert(directed.size(), '{MINW, MAXW, MAXW, MINW, MAXW, MAXW});
		directed.insert(directed.size(), '{0, MAXW, MINW, MAXW, 0, MINW});
		directed.insert(directed.size(), '{0, 65536, -65536, 1, 0, -1});
		directed.insert(directed.size(), '{0, -65536, 65536, 0, 1, 0});
		directed.insert(directed.size(), '{65536, 0, 0, 0, 0, 1});
		directed.insert(directed.size(), '{-65536, 0, 0, 1, 0, 0});
		directed.insert(directed.size(), '{1, 0, 0, -1, -1, -1});
		directed.insert(directed.size(), '{-1, 0, 0, 2, 2, 2});
		directed.insert(directed.size(), '{0, 1, 0, 0, 0, 0});
		directed.insert(directed.size(), '{0, 0, -1, 0, 0, 0});
		directed.insert(directed.size(), '{5, 3, 7, 1, 2, 3});
		directed.insert(directed.size(), '{123456, 65536, 0, -7, 9, 11});
		directed.insert(directed.size(), '{-123456, 65536, 0, 7, -9, 11});
		directed.insert(directed.size(), '{100, 100, 100, -5, -5, -5});
		directed.insert(directed.size(), '{3, 2, 4, 32'h55555555, 32'hAAAAAAAA, 0});
		foreach (directed[i])
			send_sample(directed[i]);

		for (int n = 0; n < 1300; n++) begin
			if (n == 430) begin
				snd_idle_pct = 76;
				rcv_idle_pct = 16;
			end
			if (n == 860) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (n == 900)
				hold_req = 1'b1;
			s = rand_sample();
			send_sample(s);
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/oil_pkg.sv
rtl/oil_isqrt.sv
rtl/oil_div3.sv
rtl/oil_cordic.sv
rtl/octahedral_invariants_lode.sv
rtl/oil_checker.sv
verif/tb_top.sv
